/* rtl/core/sbpw_pkg.sv */
// ----------------------------------------------------------------------------
// sbpw_pkg
// Shared types, constants and the dither function of the spectrum bar
// pixel writer.
// ----------------------------------------------------------------------------
package sbpw_pkg;

   localparam int NUM_BANDS   = 8;
   localparam int BAR_LEN     = 8;
   localparam int RED_STEP    = 16;
   localparam int LEN_SHIFT   = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] DITHER_MASK = 8'h07;
   localparam logic [3:0] START_COL   = 4'd7;
   localparam logic [3:0] LAST_STEP   = 4'(2 * BAR_LEN - 1);

   typedef struct packed {
      logic       channel;
      logic [2:0] band;
      logic [2:0] len;     // index of the last lit position
      logic [7:0] green;
      logic [7:0] blue;
   } sbpw_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sbpw_qstat_type;

   // s = ((m + (x>>3))*2 + ~(m>>2)) mod 16, d = ((s>>1) + (x>>1)) mod 8
   function automatic logic [7:0] dither(input logic [7:0] x, input logic [7:0] m);
      logic [2:0] lo;
      logic [3:0] s;
      logic [2:0] d;
      lo = m[2:0] + x[5:3];
      s  = {lo, 1'b0} + ~m[5:2];
      d  = s[3:1] + x[3:1];
      return x ^ {5'b0, d};
   endfunction

endpackage

/* rtl/core/sbpw_if.sv */
// ----------------------------------------------------------------------------
// sbpw_if
// Request and response channels of the spectrum bar pixel writer.
// ----------------------------------------------------------------------------
interface sbpw_req_if;
   logic       valid;
   logic       ready;
   logic       channel;
   logic [2:0] band;
   logic [7:0] magnitude;
   logic [7:0] phase;

   modport source(output valid, channel, band, magnitude, phase, input ready);
   modport sink(input valid, channel, band, magnitude, phase, output ready);
endinterface

interface sbpw_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] pixel_row;
   logic [3:0] pixel_col;
   logic [7:0] green;
   logic [7:0] red;
   logic [7:0] blue;
   logic       last;

   modport source(output valid, pixel_row, pixel_col, green, red, blue, last,
                  input ready);
   modport sink(input valid, pixel_row, pixel_col, green, red, blue, last,
                output ready);
endinterface

/* rtl/core/sbpw_front.sv */
// ----------------------------------------------------------------------------
// sbpw_front
// Accepts requests, drops out-of-range bands, dithers green and blue through
// the shared dither byte and pushes one bar descriptor into the queue.
// ----------------------------------------------------------------------------
module sbpw_front (
   input  logic                     clock,
   input  logic                     reset,
   sbpw_req_if.sink                 req,
   input  sbpw_pkg::sbpw_qstat_type qstat,
   output logic                     push,
   output sbpw_pkg::sbpw_entry_type entry
);

   logic [7:0] dither_ff;
   logic [7:0] dither_in;
   logic [7:0] green_val;
   logic [7:0] blue_val;
   logic       band_ok;

   assign req.ready = !qstat.full;

   always_comb begin
      green_val = sbpw_pkg::dither(req.magnitude, dither_ff);
      blue_val  = sbpw_pkg::dither(req.phase, green_val);
      band_ok   = int'(req.band) < sbpw_pkg::NUM_BANDS;
      push      = req.valid && req.ready && band_ok;

      entry.channel = req.channel;
      entry.band    = req.band;
      entry.len     = 3'(req.magnitude >> sbpw_pkg::LEN_SHIFT);
      entry.green   = green_val;
      entry.blue    = blue_val;

      // advance the dither byte only for items that draw a bar
      dither_in = push ? blue_val : dither_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_ff <= 8'd0;
      end else begin
         dither_ff <= dither_in;
      end
   end

endmodule

/* rtl/core/sbpw_queue.sv */
// ----------------------------------------------------------------------------
// sbpw_queue
// Short FIFO of bar descriptors between the front and the back.
// ----------------------------------------------------------------------------
module sbpw_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sbpw_pkg::sbpw_entry_type push_entry,
   input  logic                     pop,
   output sbpw_pkg::sbpw_entry_type head,
   output sbpw_pkg::sbpw_qstat_type qstat
);

   localparam int PtrW = (sbpw_pkg::QUEUE_DEPTH > 1) ? $clog2(sbpw_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(sbpw_pkg::QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(sbpw_pkg::QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] Depth   = CntW'(sbpw_pkg::QUEUE_DEPTH);

   sbpw_pkg::sbpw_entry_type slot_ff [sbpw_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      qstat.full  = count_ff == Depth;
      qstat.empty = count_ff == '0;
      head        = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/sbpw_back.sv */
// ----------------------------------------------------------------------------
// sbpw_back
// Walks one bar descriptor through its sixteen pixel writes and holds each
// write in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module sbpw_back (
   input  logic                     clock,
   input  logic                     reset,
   input  sbpw_pkg::sbpw_entry_type head,
   input  sbpw_pkg::sbpw_qstat_type qstat,
   output logic                     pop,
   sbpw_rsp_if.source               rsp
);

   sbpw_pkg::sbpw_entry_type cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [3:0] row_ff, row_in;
   logic [3:0] col_ff, col_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] blue_ff, blue_in;
   logic       last_ff, last_in;

   logic       adv;
   logic       at_last;
   logic [2:0] led;
   logic       dim;

   always_comb begin
      adv     = busy_ff && (!valid_ff || rsp.ready);
      at_last = step_ff == sbpw_pkg::LAST_STEP;
      pop     = !qstat.empty && (!busy_ff || (adv && at_last));

      led = step_ff[3:1];
      dim = led > cur_ff.len;

      cur_in  = cur_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (pop) begin
         cur_in  = head;
         busy_in = 1'b1;
         step_in = '0;
      end else if (adv) begin
         step_in = step_ff + 1'b1;
         if (at_last) begin
            busy_in = 1'b0;
         end
      end

      // pixel for the current step; upper row first
      row_in   = {cur_ff.band, step_ff[0]};
      col_in   = cur_ff.channel ? (sbpw_pkg::START_COL + 4'd1 - {1'b0, led})
                                : (sbpw_pkg::START_COL + {1'b0, led});
      green_in = dim ? (cur_ff.green & sbpw_pkg::DITHER_MASK) : cur_ff.green;
      blue_in  = dim ? (cur_ff.blue & sbpw_pkg::DITHER_MASK) : cur_ff.blue;
      red_in   = dim ? 8'd0 : 8'(int'(led) * sbpw_pkg::RED_STEP);
      last_in  = at_last;

      valid_in = valid_ff;
      if (adv) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (adv) begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         green_ff <= green_in;
         red_ff   <= red_in;
         blue_ff  <= blue_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.pixel_row = row_ff;
   assign rsp.pixel_col = col_ff;
   assign rsp.green     = green_ff;
   assign rsp.red       = red_ff;
   assign rsp.blue      = blue_ff;
   assign rsp.last      = last_ff;

endmodule

/* rtl/core/spectrum_bar_pixel_writer.sv */
// ----------------------------------------------------------------------------
// spectrum_bar_pixel_writer
// Turns one band snapshot into the sixteen pixel writes of its bar.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries channel, band, magnitude and phase; a word moves when
//   valid and ready are both high. Each word yields sixteen words on rsp_bus:
//   the 8 bar positions in order, upper row then lower row, last set on the
//   sixteenth. Bands at or above the band count are dropped with no output.
//   From idle, a taken item passes the FIFO and the descriptor register
//   before its first write. Throughput: one write per cycle while rsp_bus
//   is ready, set by the step counter and the single output register.
//   The front dithers green and blue at acceptance and queues the result in
//   a 2-deep FIFO, so up to two items wait while a bar is being written.
//   When the receiver stalls, the output register holds its word, the step
//   counter stops, the FIFO fills and req_bus.ready then drops.
//   Reset clears the dither byte to zero and empties the FIFO and the
//   output register; no word is pending after reset.
// ----------------------------------------------------------------------------
module spectrum_bar_pixel_writer (
   input  logic       clock,
   input  logic       reset,
   sbpw_req_if.sink   req_bus,
   sbpw_rsp_if.source rsp_bus
);

   logic                     push;
   logic                     pop;
   sbpw_pkg::sbpw_entry_type entry;
   sbpw_pkg::sbpw_entry_type head;
   sbpw_pkg::sbpw_qstat_type qstat;

   sbpw_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .qstat (qstat),
      .push  (push),
      .entry (entry)
   );

   sbpw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   sbpw_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");

   a_queue_count_sane: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue both full and empty");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.pixel_col >= 4'd1) && (rsp_bus.pixel_col <= 4'd14))
      else $error("pixel column outside bar area");

   a_no_bubble_in_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last |=> rsp_bus.valid)
      else $error("gap inside a bar");

endmodule

/* tb/spectrum_bar_pixel_writer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_bar_pixel_writer_tb
// Self-checking bench for the spectrum bar pixel writer. Band snapshots go
// in on req_bus. A local bar model tracks the shared dither byte and queues
// the sixteen pixel words each snapshot should produce. Every rsp_bus word
// is checked against the oldest queued word. The traffic covers field
// extremes, every bar length, back-to-back words, random gaps and stalls,
// and one long output hold-off that fills the block.
// ----------------------------------------------------------------------------
module spectrum_bar_pixel_writer_tb;
   import sbpw_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int TAIL_CYCLES  = 32;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [3:0] row;
      logic [3:0] col;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic       last;
   } pixel_word_t;

   logic clock = 1'b0;
   logic reset;

   sbpw_req_if req_bus ();
   sbpw_rsp_if rsp_bus ();

   spectrum_bar_pixel_writer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   pixel_word_t expected_pixels[$];
   logic [7:0]  dither_state;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          req_gaps_on = 1'b0;
   bit          rsp_stalls_on = 1'b0;
   int          hold_request = 0;
   int          stall_left = 0;
   pixel_word_t want;

   // dither a byte against the running memory and return the new memory value
   function automatic logic [7:0] dither_byte(input logic [7:0] x, input logic [7:0] m);
      int unsigned mu, xu, s, d;
      mu = m;
      xu = x;
      s  = ((mu + (xu >> 3)) * 2 + ~(mu >> 2)) & 32'd15;
      d  = ((s >> 1) + (xu >> 1)) & 32'd7;
      return x ^ 8'(d);
   endfunction

   // work out the sixteen pixel words of one accepted snapshot
   task automatic draw_bar(input logic ch, input logic [2:0] band,
                           input logic [7:0] mag, input logic [7:0] ph);
      logic [7:0]  g, b, r;
      int          lit, n;
      pixel_word_t px;
      if (band >= NUM_BANDS) return;
      g = dither_byte(mag, dither_state);
      dither_state = g;
      b = dither_byte(ph, dither_state);
      dither_state = b;
      lit = (mag >> LEN_SHIFT) + 1;
      n = 0;
      for (int led = 0; led < BAR_LEN; led++) begin
         r = 8'(RED_STEP * led);
         // dim from the first unlit position onward and keep it dimmed
         if (led >= lit) begin
            g = g & DITHER_MASK;
            b = b & DITHER_MASK;
            r = r & DITHER_MASK;
         end
         for (int k = 0; k < 2; k++) begin
            px.row   = 4'(2 * band + k);
            px.col   = ch ? 4'(START_COL + 1 - led) : 4'(START_COL + led);
            px.green = g;
            px.red   = r;
            px.blue  = b;
            px.last  = (n == 2 * BAR_LEN - 1);
            expected_pixels.push_back(px);
            n++;
         end
      end
   endtask

   function automatic int pick_gap();
      int roll;
      if (!req_gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // offer one snapshot word and hold it until the block takes it
   task automatic send_snapshot(input logic ch, input logic [2:0] band,
                                input logic [7:0] mag, input logic [7:0] ph);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.channel   <= ch;
      req_bus.band      <= band;
      req_bus.magnitude <= mag;
      req_bus.phase     <= ph;
      do @(posedge clock); while (!req_bus.ready);
      draw_bar(ch, band, mag, ph);
   endtask

   task automatic send_random_snapshot();
      send_snapshot(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task automatic test_field_extremes();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      // first word sees the dither memory at its reset value
      send_snapshot(1'b0, 3'd0, 8'd0, 8'd0);
      send_snapshot(1'b1, 3'd7, 8'd255, 8'd255);
      send_snapshot(1'b0, 3'd7, 8'd255, 8'd0);
      send_snapshot(1'b1, 3'd0, 8'd0, 8'd255);
   endtask

   task automatic test_bar_lengths();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      // both edges of every length step
      for (int k = 0; k < BAR_LEN; k++) begin
         send_snapshot(1'(k), 3'(k), 8'(32 * k), 8'($urandom_range(0, 255)));
         send_snapshot(1'(k + 1), 3'(7 - k), 8'(32 * k + 31), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_back_to_back();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      repeat (30) send_random_snapshot();
   endtask

   task automatic test_random_traffic();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (400) send_random_snapshot();
   endtask

   task automatic test_output_backpressure();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b1;
      // hold the receiver off while words keep coming so the queue fills
      hold_request = 300;
      repeat (20) send_random_snapshot();
   endtask

   // receiver side: random stalls plus requested long holds
   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (!rsp_stalls_on || $urandom_range(0, 99) < 70) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= 1'b0;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(0, 2);
      end
   end

   // check every accepted pixel word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected word: row %0d col %0d g %02h r %02h b %02h last %0b",
                        rsp_bus.pixel_row, rsp_bus.pixel_col, rsp_bus.green,
                        rsp_bus.red, rsp_bus.blue, rsp_bus.last);
         end else begin
            want = expected_pixels.pop_front();
            if (want.row !== rsp_bus.pixel_row || want.col !== rsp_bus.pixel_col ||
                want.green !== rsp_bus.green || want.red !== rsp_bus.red ||
                want.blue !== rsp_bus.blue || want.last !== rsp_bus.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"mismatch: expected row %0d col %0d g %02h r %02h b %02h last %0b,",
                            " got row %0d col %0d g %02h r %02h b %02h last %0b"},
                           want.row, want.col, want.green, want.red, want.blue,
                           want.last, rsp_bus.pixel_row, rsp_bus.pixel_col,
                           rsp_bus.green, rsp_bus.red, rsp_bus.blue, rsp_bus.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("spectrum_bar_pixel_writer test failed");
         $finish;
      end
   end

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.channel   <= 1'b0;
      req_bus.band      <= 3'd0;
      req_bus.magnitude <= 8'd0;
      req_bus.phase     <= 8'd0;
      dither_state = 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_bar_lengths();
      test_back_to_back();
      test_random_traffic();
      test_output_backpressure();

      // drop valid, drain, then watch for stray words
      req_bus.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      rsp_stalls_on = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("spectrum_bar_pixel_writer test passed");
      else
         $display("spectrum_bar_pixel_writer test failed");
      $finish;
   end

endmodule

/* spectrum_bar_pixel_writer.f */
rtl/core/sbpw_pkg.sv
rtl/core/sbpw_if.sv
rtl/core/sbpw_front.sv
rtl/core/sbpw_queue.sv
rtl/core/sbpw_back.sv
rtl/core/spectrum_bar_pixel_writer.sv
tb/spectrum_bar_pixel_writer_tb.sv
